// ----- src/mpfb_pkg.sv -----
package mpfb_pkg;

    // Panel geometry and readout chunk size
    localparam int PANEL_COLUMNS = 128;
    localparam int PANEL_ROWS    = 64;
    localparam int CHUNK_BYTES   = 16;

    localparam int PAGE_COUNT  = PANEL_ROWS / 8;
    localparam int STORE_BYTES = PANEL_COLUMNS * PAGE_COUNT;

    // Store address width and signed width for the draw address math
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int SGN_W  = ADDR_W + 3;

    // Width used for coordinate extent compares
    localparam int EXT_W = 9;

    // Byte counter inside one readout chunk
    localparam int CHUNK_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

    // Readout address: wide enough for chunk*CHUNK_BYTES+k and for STORE_BYTES
    localparam int CHUNK_IDX_W = 6;
    localparam int RD_SPAN_W   = CHUNK_IDX_W + CHUNK_W;
    localparam int RD_ADDR_W   = (RD_SPAN_W > ADDR_W + 1) ? RD_SPAN_W : ADDR_W + 1;

    localparam logic [7:0] FILL_WHITE = 8'hFF;
    localparam logic [7:0] FILL_BLACK = 8'h00;

    // Request action codes
    localparam logic [1:0] ACT_DRAW = 2'd0;
    localparam logic [1:0] ACT_FILL = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Orientation codes
    localparam logic [1:0] ORI_PORTRAIT      = 2'd0;
    localparam logic [1:0] ORI_LANDSCAPE     = 2'd1;
    localparam logic [1:0] ORI_PORTRAIT_REV  = 2'd2;
    localparam logic [1:0] ORI_LANDSCAPE_REV = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_FILL,
        ST_RD_ISSUE,
        ST_RD_LOAD,
        ST_RD_WAIT
    } mpfb_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic draw_read;
        logic draw_write;
        logic fill_write;
        logic rd_read;
        logic out_load;
    } mpfb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fill_done;
        logic out_last;
    } mpfb_status_t;

endpackage

// ----- src/mpfb_ctrl.sv -----
module mpfb_ctrl
    import mpfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [1:0]   action,
    input  logic         out_ready,
    input  mpfb_status_t status,
    output logic         in_ready,
    output logic         out_valid,
    output mpfb_cmd_t    cmd
);

    mpfb_state_t state_reg;
    mpfb_state_t state_next;

    // State register; reset starts with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ACT_DRAW: state_next = ST_DRAW_RD;
                        ACT_FILL: state_next = ST_FILL;
                        ACT_READ: state_next = ST_RD_ISSUE;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DRAW_RD:  state_next = ST_DRAW_WR;
            ST_DRAW_WR:  state_next = ST_IDLE;
            ST_FILL:
            begin
                if (status.fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ISSUE: state_next = ST_RD_LOAD;
            ST_RD_LOAD:  state_next = ST_RD_WAIT;
            ST_RD_WAIT:
            begin
                if (out_ready)
                begin
                    state_next = status.out_last ? ST_IDLE : ST_RD_LOAD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DRAW_RD:  cmd.draw_read  = 1'b1;
            ST_DRAW_WR:  cmd.draw_write = 1'b1;
            ST_FILL:     cmd.fill_write = 1'b1;
            ST_RD_ISSUE: cmd.rd_read    = 1'b1;
            ST_RD_LOAD:  cmd.out_load   = 1'b1;
            ST_RD_WAIT:
            begin
                out_valid   = 1'b1;
                // fetch the next byte as soon as this one is taken
                cmd.rd_read = out_ready && !status.out_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/mpfb_dpath.sv -----
module mpfb_dpath
    import mpfb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_data,
    input  logic [6:0]   pos_x,
    input  logic [6:0]   pos_y,
    input  logic         colour,
    input  logic [1:0]   action,
    input  logic [5:0]   chunk,
    input  mpfb_cmd_t    cmd,
    output mpfb_status_t status,
    output logic [7:0]   data_byte,
    output logic         last
);

    localparam logic signed [SGN_W-1:0] COLS_S  = SGN_W'(PANEL_COLUMNS);
    localparam logic signed [SGN_W-1:0] PAGES_S = SGN_W'(PAGE_COUNT);
    localparam logic signed [SGN_W-1:0] STORE_S = SGN_W'(STORE_BYTES);
    localparam logic signed [SGN_W-1:0] ONE_S   = SGN_W'(1);

    // Frame store
    logic [7:0] mem [STORE_BYTES];
    logic [7:0] mem_rdata_reg;

    // Configuration and captured request
    logic [1:0]        orient_reg;
    logic [ADDR_W-1:0] draw_addr_reg;
    logic [2:0]        draw_bit_reg;
    logic              draw_ok_reg;
    logic              colour_reg;
    logic [7:0]        fill_val_reg;
    logic [ADDR_W-1:0] fill_cnt_reg;
    logic [5:0]        chunk_reg;
    logic [CHUNK_W-1:0] k_reg;
    logic              rd_oor_reg;
    logic [7:0]        data_reg;
    logic              last_reg;

    // Draw address math
    logic signed [SGN_W-1:0] xs, ys, xps, yps, addr_s;
    logic [2:0]              bit_sel;
    logic                    in_extent;
    logic                    draw_ok;
    logic [EXT_W-1:0]        width_lim, height_lim;

    // Readout address
    logic [RD_ADDR_W-1:0] rd_addr;
    logic                 rd_oor;

    // Memory port selection
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        bit_mask;

    assign xs  = $signed(SGN_W'(pos_x));
    assign ys  = $signed(SGN_W'(pos_y));
    assign xps = $signed(SGN_W'(pos_x[6:3]));
    assign yps = $signed(SGN_W'(pos_y[6:3]));

    // Logical extents swap in the portrait forms
    assign width_lim  = orient_reg[0] ? EXT_W'(PANEL_COLUMNS) : EXT_W'(PANEL_ROWS);
    assign height_lim = orient_reg[0] ? EXT_W'(PANEL_ROWS) : EXT_W'(PANEL_COLUMNS);
    assign in_extent  = (EXT_W'(pos_x) < width_lim) && (EXT_W'(pos_y) < height_lim);

    // Coordinate to byte and bit under each orientation
    always_comb
    begin
        case (orient_reg)
            ORI_PORTRAIT:
            begin
                addr_s  = COLS_S * (PAGES_S - ONE_S - xps) + ys;
                bit_sel = ~pos_x[2:0];
            end
            ORI_LANDSCAPE:
            begin
                addr_s  = xs + yps * COLS_S;
                bit_sel = pos_y[2:0];
            end
            ORI_PORTRAIT_REV:
            begin
                addr_s  = COLS_S - ONE_S - ys + xps * COLS_S;
                bit_sel = pos_x[2:0];
            end
            default:
            begin
                addr_s  = STORE_S - ONE_S - xs - yps * COLS_S;
                bit_sel = ~pos_y[2:0];
            end
        endcase
    end

    assign draw_ok = in_extent && (addr_s >= 0) && (addr_s < STORE_S);

    // Readout byte address and past-the-end check
    assign rd_addr = RD_ADDR_W'(chunk_reg) * RD_ADDR_W'(CHUNK_BYTES) + RD_ADDR_W'(k_reg);
    assign rd_oor  = !(rd_addr < RD_ADDR_W'(STORE_BYTES));

    // Status back to the controller
    assign status.fill_done = (fill_cnt_reg == ADDR_W'(STORE_BYTES - 1));
    assign status.out_last  = last_reg;

    // Single memory port: read-modify-write for draws, sweep for fills, reads for readout
    assign bit_mask = 8'(1) << draw_bit_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = draw_addr_reg;
        mem_wdata = fill_val_reg;
        if (cmd.fill_write)
        begin
            mem_we   = 1'b1;
            mem_addr = fill_cnt_reg;
        end
        else if (cmd.draw_write)
        begin
            mem_we    = draw_ok_reg;
            mem_wdata = colour_reg ? (mem_rdata_reg | bit_mask)
                                   : (mem_rdata_reg & ~bit_mask);
        end
        else if (cmd.draw_read)
        begin
            mem_re = 1'b1;
        end
        else if (cmd.rd_read)
        begin
            mem_re   = 1'b1;
            mem_addr = rd_addr[ADDR_W-1:0];
        end
    end

    // Store array
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg   <= ORI_LANDSCAPE;
            fill_cnt_reg <= '0;
            fill_val_reg <= FILL_BLACK;
            k_reg        <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                orient_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                fill_cnt_reg <= '0;
                k_reg        <= '0;
                if (action == ACT_FILL)
                begin
                    fill_val_reg <= colour ? FILL_WHITE : FILL_BLACK;
                end
            end
            else if (cmd.fill_write)
            begin
                fill_cnt_reg <= fill_cnt_reg + ADDR_W'(1);
            end
            if (cmd.out_load)
            begin
                last_reg <= (k_reg == CHUNK_W'(CHUNK_BYTES - 1));
                k_reg    <= k_reg + CHUNK_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            draw_addr_reg <= addr_s[ADDR_W-1:0];
            draw_bit_reg  <= bit_sel;
            draw_ok_reg   <= draw_ok;
            colour_reg    <= colour;
            chunk_reg     <= chunk;
        end
        if (cmd.rd_read)
        begin
            rd_oor_reg <= rd_oor;
        end
        if (cmd.out_load)
        begin
            data_reg <= rd_oor_reg ? 8'h00 : mem_rdata_reg;
        end
    end

    assign data_byte = data_reg;
    assign last      = last_reg;

endmodule

// ----- src/monochrome_page_framebuffer.sv -----
// One-bit-per-pixel framebuffer in vertical-byte page layout, held in a
// single-port 1024-byte memory. After reset the block runs a clearing pass
// with in_ready low (orientation writes are taken as ever). A draw request
// is accepted, then reads the byte and writes it back, a read-modify-write
// on the one memory port; off-panel draws take the same time and change
// nothing. A fill request writes one byte per cycle. A readout request emits
// 16 bytes, the next byte fetched only once out_ready takes the current one,
// the last one flagged; addresses past the store read as zero. Requests are
// handled one at a time; in_ready is high only while idle. Orientation
// resets to landscape.
module monochrome_page_framebuffer
    import mpfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [6:0] pos_x,
    input  logic [6:0] pos_y,
    input  logic       colour,
    input  logic [5:0] chunk,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       last
);

    mpfb_cmd_t    cmd;
    mpfb_status_t status;

    // Sequencer
    mpfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Store, address math and output register
    mpfb_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .colour    (colour),
        .action    (action),
        .chunk     (chunk),
        .cmd       (cmd),
        .status    (status),
        .data_byte (data_byte),
        .last      (last)
    );

endmodule
